>>> rtl/bgi_pkg.sv
// Package for the bilinear grid interpolator: payload and control structs,
// field widths, register indexes and parameter defaults. No dependencies.
package bgi_pkg;

    // Fixed field widths of the transfer payloads.
    localparam int SAMPLE_W = 16;
    localparam int INDEX_W  = 8;
    localparam int COORD_W  = 16;
    localparam int CFG_W    = 9;
    localparam int CFG_IDX_W = 1;
    // Width used to compare grid coordinates (one bit of headroom for the +1 neighbor).
    localparam int CMP_W    = COORD_W + 1;

    // Parameter defaults for the top level.
    localparam int GRID_ROWS_DEF = 256;
    localparam int GRID_COLS_DEF = 256;
    localparam int FRAC_BITS_DEF = 8;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] ROWS_RESET = CFG_W'(256);
    localparam logic [CFG_W-1:0] COLS_RESET = CFG_W'(256);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 1'b1;

    // Operation codes.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic                       opcode;
        logic [INDEX_W-1:0]         sample_row;
        logic [INDEX_W-1:0]         sample_col;
        logic signed [SAMPLE_W-1:0] sample_value;
        logic [COORD_W-1:0]         query_row;
        logic [COORD_W-1:0]         query_col;
    } bgi_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] interp_value;
        logic                       out_of_range;
    } bgi_result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;      // capture the accepted item
        logic       store;     // write the captured sample into the grid
        logic       rd_en;     // read one neighbor and form its weight
        logic [1:0] rd_sel;    // bit 1 selects the far row, bit 0 the far column
        logic       mul_en;    // multiply the read sample by its weight
        logic       acc_first; // start the sum with the current product
        logic       acc_add;   // add the current product to the sum
        logic       res_en;    // register the result and raise the strobe
        logic       res_oor;   // the result is the out-of-range answer
    } bgi_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_query;
        logic oor;
    } bgi_status_t;

endpackage

>>> rtl/bgi_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module bgi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/bgi_ctrl.sv
// Controller of the bilinear grid interpolator: sequences a write or the
// four-neighbor query. Depends on bgi_pkg.
module bgi_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  bgi_pkg::bgi_status_t status,
    output logic                busy,
    output bgi_pkg::bgi_cmd_t   cmd
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_CHECK  = 8'b0000_0010,
        ST_RD01   = 8'b0000_0100,
        ST_RD10   = 8'b0000_1000,
        ST_RD11   = 8'b0001_0000,
        ST_MUL11  = 8'b0010_0000,
        ST_ACC11  = 8'b0100_0000,
        ST_FINISH = 8'b1000_0000
    } bgi_state_t;

    bgi_state_t state_reg;
    bgi_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!status.is_query)
                begin
                    cmd.store  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (status.oor)
                begin
                    cmd.res_en  = 1'b1;
                    cmd.res_oor = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = 2'b00;
                    state_next = ST_RD01;
                end
            end
            ST_RD01:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = 2'b01;
                cmd.mul_en = 1'b1;
                state_next = ST_RD10;
            end
            ST_RD10:
            begin
                cmd.rd_en     = 1'b1;
                cmd.rd_sel    = 2'b10;
                cmd.mul_en    = 1'b1;
                cmd.acc_first = 1'b1;
                state_next    = ST_RD11;
            end
            ST_RD11:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = 2'b11;
                cmd.mul_en  = 1'b1;
                cmd.acc_add = 1'b1;
                state_next  = ST_MUL11;
            end
            ST_MUL11:
            begin
                cmd.mul_en  = 1'b1;
                cmd.acc_add = 1'b1;
                state_next  = ST_ACC11;
            end
            ST_ACC11:
            begin
                cmd.acc_add = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.res_en = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/bgi_datapath.sv
// Datapath of the bilinear grid interpolator: item register, grid RAM,
// weight multiplier, sample multiplier, accumulator and rounding.
// Depends on bgi_pkg and bgi_ram.
module bgi_datapath #(
    parameter int GRID_ROWS = bgi_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = bgi_pkg::GRID_COLS_DEF,
    parameter int FRAC_BITS = bgi_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bgi_pkg::bgi_item_t            request,
    input  logic [bgi_pkg::CFG_W-1:0]     rows_in_use,
    input  logic [bgi_pkg::CFG_W-1:0]     cols_in_use,
    input  bgi_pkg::bgi_cmd_t             cmd,
    output bgi_pkg::bgi_status_t          status,
    output bgi_pkg::bgi_result_t          result,
    output logic                          result_valid
);

    localparam int DEPTH  = GRID_ROWS * GRID_COLS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CMP_W  = bgi_pkg::CMP_W;
    localparam int SW     = bgi_pkg::SAMPLE_W;
    localparam int WF_W   = FRAC_BITS + 1;          // one-dimensional weight
    localparam int WT_W   = 2 * WF_W;               // product of two weights
    localparam int ACC_W  = 2 * FRAC_BITS + SW + 2; // weighted sum with headroom

    localparam logic [WF_W-1:0]  SCALE = WF_W'(1) << FRAC_BITS;
    localparam logic [ACC_W-1:0] HALF  = ACC_W'(1) << (2 * FRAC_BITS - 1);
    localparam logic [CMP_W-1:0] ROWS_MAX = CMP_W'(GRID_ROWS);
    localparam logic [CMP_W-1:0] COLS_MAX = CMP_W'(GRID_COLS);

    bgi_pkg::bgi_item_t item_reg;

    logic [WF_W-1:0]  fr, fc;
    logic [CMP_W-1:0] r0, c0, r1, c1;
    logic [CMP_W-1:0] rows_lim, cols_lim;
    logic [CMP_W-1:0] row_pick, col_pick;
    logic [WF_W-1:0]  wr_pick, wc_pick;
    logic [ADDR_W-1:0] raddr, waddr;
    logic              write_ok;
    logic [SW-1:0]     rdata;

    logic [WT_W-1:0]         wt_reg;
    logic signed [ACC_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [ACC_W-1:0] rounded;

    bgi_pkg::bgi_result_t result_reg, result_next;
    logic                 valid_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= request;
        end
    end

    // Integer and fraction parts of the query point; the far neighbor is
    // the next row or column only when the fraction is not zero.
    assign fr = {1'b0, item_reg.query_row[FRAC_BITS-1:0]};
    assign fc = {1'b0, item_reg.query_col[FRAC_BITS-1:0]};
    assign r0 = CMP_W'(item_reg.query_row) >> FRAC_BITS;
    assign c0 = CMP_W'(item_reg.query_col) >> FRAC_BITS;
    assign r1 = r0 + CMP_W'(fr != '0);
    assign c1 = c0 + CMP_W'(fc != '0);

    assign rows_lim = (CMP_W'(rows_in_use) > ROWS_MAX) ? ROWS_MAX : CMP_W'(rows_in_use);
    assign cols_lim = (CMP_W'(cols_in_use) > COLS_MAX) ? COLS_MAX : CMP_W'(cols_in_use);

    assign status.is_query = (item_reg.opcode == bgi_pkg::OP_QUERY);
    assign status.oor      = (r1 >= rows_lim) || (c1 >= cols_lim);

    // Neighbor selection and its weight.
    assign row_pick = cmd.rd_sel[1] ? r1 : r0;
    assign col_pick = cmd.rd_sel[0] ? c1 : c0;
    assign wr_pick  = cmd.rd_sel[1] ? fr : SCALE - fr;
    assign wc_pick  = cmd.rd_sel[0] ? fc : SCALE - fc;

    assign raddr = ADDR_W'(ADDR_W'(row_pick) * ADDR_W'(GRID_COLS)) + ADDR_W'(col_pick);
    assign waddr = ADDR_W'(ADDR_W'(item_reg.sample_row) * ADDR_W'(GRID_COLS))
                 + ADDR_W'(item_reg.sample_col);
    assign write_ok = (CMP_W'(item_reg.sample_row) < ROWS_MAX)
                   && (CMP_W'(item_reg.sample_col) < COLS_MAX);

    bgi_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_grid (
        .clk   (clk),
        .we    (cmd.store && write_ok),
        .waddr (waddr),
        .wdata (item_reg.sample_value),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    // The weight is formed in the read cycle so it lines up with the sample.
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            wt_reg <= WT_W'(wr_pick) * WT_W'(wc_pick);
        end
    end

    assign prod_next = $signed(rdata) * $signed({1'b0, wt_reg});

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.acc_first)
        begin
            acc_next = prod_reg;
        end
        else if (cmd.acc_add)
        begin
            acc_next = acc_reg + prod_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= prod_next;
        end
        acc_reg <= acc_next;
    end

    // Round to nearest with halves toward plus infinity: add half, then an
    // arithmetic shift, which the slice of the sum below provides.
    assign rounded = acc_reg + $signed(HALF);

    always_comb
    begin
        result_next = result_reg;
        if (cmd.res_en)
        begin
            if (cmd.res_oor)
            begin
                result_next.interp_value = '0;
                result_next.out_of_range = 1'b1;
            end
            else
            begin
                result_next.interp_value = rounded[2 * FRAC_BITS +: SW];
                result_next.out_of_range = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cmd.res_en;
        end
    end

    assign result       = result_reg;
    assign result_valid = valid_reg;

endmodule

>>> rtl/bilinear_grid_interpolator.sv
// Top level of the bilinear grid interpolator: configuration registers,
// controller and datapath. Depends on bgi_pkg, bgi_ctrl and bgi_datapath.
//
//   Channel   Handshake                 Payload
//   -------   -----------------------   -----------------------------------
//   request   start high, busy low      request (bgi_item_t)
//   result    result_valid, one cycle   result (bgi_result_t)
//   config    cfg_we                    cfg_index, cfg_data
//
// A write keeps busy high only in the check state after acceptance; a query
// whose cell is out of range does the same and strobes its result in the
// cycle after. An in-range query stays busy through the check, read, last
// multiply, last add and finish states and strobes its result right after:
// the four neighbors come one at a time through the single read port of the
// grid RAM and pass through one shared sample multiplier. The grid memory is
// not cleared at reset; reset idles the controller, clears the result strobe
// and sets both counts in use to 256. Results cannot be stalled, and a new
// item may be accepted in the same cycle that a result is strobed.
module bilinear_grid_interpolator #(
    parameter int GRID_ROWS = bgi_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = bgi_pkg::GRID_COLS_DEF,
    parameter int FRAC_BITS = bgi_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  bgi_pkg::bgi_item_t              request,
    output logic                            result_valid,
    output bgi_pkg::bgi_result_t            result,
    input  logic                            cfg_we,
    input  logic [bgi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bgi_pkg::CFG_W-1:0]       cfg_data
);

    logic [bgi_pkg::CFG_W-1:0] rows_in_use_reg, rows_in_use_next;
    logic [bgi_pkg::CFG_W-1:0] cols_in_use_reg, cols_in_use_next;

    bgi_pkg::bgi_cmd_t    cmd;
    bgi_pkg::bgi_status_t status;

    // Configuration registers. The user must write them only while the block is idle; the block does not enforce it.
    always_comb
    begin
        rows_in_use_next = rows_in_use_reg;
        cols_in_use_next = cols_in_use_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                bgi_pkg::REG_ROWS_IN_USE: rows_in_use_next = cfg_data;
                bgi_pkg::REG_COLS_IN_USE: cols_in_use_next = cfg_data;
                default:
                begin
                    rows_in_use_next = rows_in_use_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_in_use_reg <= bgi_pkg::ROWS_RESET;
            cols_in_use_reg <= bgi_pkg::COLS_RESET;
        end
        else
        begin
            rows_in_use_reg <= rows_in_use_next;
            cols_in_use_reg <= cols_in_use_next;
        end
    end

    // The controller takes the start pulse only when idle, so the load
    // command marks exactly the accepted transfers.
    bgi_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    bgi_datapath #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request),
        .rows_in_use  (rows_in_use_reg),
        .cols_in_use  (cols_in_use_reg),
        .cmd          (cmd),
        .status       (status),
        .result       (result),
        .result_valid (result_valid)
    );

`ifndef NO_ASSERTIONS
    // An accepted item always occupies the block in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not make the block busy");

    // A result is strobed only at the end of work, when the block was busy and is now idle, and never while busy.
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy) && !busy)
        else $error("result strobe outside the end of an item");

    // The out-of-range answer always carries a zero value.
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.out_of_range |-> result.interp_value == '0)
        else $error("out-of-range result with a nonzero value");
`endif

endmodule
